@@ sv/qob_pkg.sv @@
// Shared widths, stage counts and types for the quaternion orientation basis block.
// No dependencies; every other file of the block refers to this package by scoped names.
package qob_pkg;

    localparam int Q_W           = 16;
    localparam int OUT_W         = 16;
    localparam int FRACTION_BITS = 14;
    localparam int GUARD_BITS    = 15;
    localparam int NUM_LANE      = 6;

    localparam int PROD_W  = 2 * Q_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int N_W     = PROD_W + 3;
    localparam int ROOT_W  = (SUM_W + 2 * GUARD_BITS + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int QUO_W   = Q_W + 2;
    localparam int LR_W    = QUO_W;
    localparam int REM_W   = N_W + GUARD_BITS + 2;
    localparam int UP_P_W  = 2 * LR_W;
    localparam int UP_D_W  = UP_P_W + 1;

    // Input register, products, sums, root stages, divide setup, divide stages,
    // sign, cross products, output.
    localparam int LATENCY = 3 + ROOT_W + 1 + QUO_W + 3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic                zero;
        logic [NUM_LANE-1:0] neg;
    } t_div_side;

    // Returns {clip, value}: the value clipped to the output range.
    function automatic logic [OUT_W:0] sat_out(input logic signed [UP_D_W-1:0] v);
        logic [OUT_W:0] res;
        if (v > UP_D_W'(OUT_MAX)) begin
            res = {1'b1, OUT_MAX};
        end else if (v < UP_D_W'(OUT_MIN)) begin
            res = {1'b1, OUT_MIN};
        end else begin
            res = {1'b0, v[OUT_W-1:0]};
        end
        return res;
    endfunction

endpackage

@@ sv/qob_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on qob_pkg for the radicand and root widths.
module qob_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [qob_pkg::RAD_W-1:0]  i_rad,
    output logic                       o_valid,
    output logic [qob_pkg::ROOT_W-1:0] o_root
);

    logic [qob_pkg::RAD_W-1:0]  r_rem  [qob_pkg::ROOT_W];
    logic [qob_pkg::ROOT_W-1:0] r_root [qob_pkg::ROOT_W];
    logic                       r_vld  [qob_pkg::ROOT_W];

    for (genvar k = 0; k < qob_pkg::ROOT_W; k++) begin : g_stage
        localparam int B = qob_pkg::ROOT_W - 1 - k;
        logic [qob_pkg::RAD_W-1:0]  rem_in;
        logic [qob_pkg::RAD_W-1:0]  trial;
        logic [qob_pkg::ROOT_W-1:0] root_in;
        logic                       vld_in;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // The remainder holds radicand minus root squared; setting this bit adds
        // twice the root shifted by the bit, plus the bit squared.
        assign trial = (qob_pkg::RAD_W'(root_in) << (B + 1))
                     | (qob_pkg::RAD_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[k]  <= rem_in - trial;
                r_root[k] <= root_in | (qob_pkg::ROOT_W'(1) << B);
            end else begin
                r_rem[k]  <= rem_in;
                r_root[k] <= root_in;
            end
        end
    end

    assign o_valid = r_vld[qob_pkg::ROOT_W-1];
    assign o_root  = r_root[qob_pkg::ROOT_W-1];

endmodule

@@ sv/qob_div.sv @@
// Pipelined restoring divider for six dividends over one shared divisor,
// one quotient bit per register stage. Depends on qob_pkg for widths and t_div_side.
module qob_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [qob_pkg::REM_W-1:0]   i_dvd [qob_pkg::NUM_LANE],
    input  logic [qob_pkg::ROOT_W:0]    i_dvs,
    input  qob_pkg::t_div_side          i_side,
    output logic                        o_valid,
    output logic [qob_pkg::QUO_W-1:0]   o_quo [qob_pkg::NUM_LANE],
    output qob_pkg::t_div_side          o_side
);

    logic [qob_pkg::REM_W-1:0] r_rem  [qob_pkg::QUO_W][qob_pkg::NUM_LANE];
    logic [qob_pkg::QUO_W-1:0] r_quo  [qob_pkg::QUO_W][qob_pkg::NUM_LANE];
    logic [qob_pkg::ROOT_W:0]  r_dvs  [qob_pkg::QUO_W];
    qob_pkg::t_div_side        r_side [qob_pkg::QUO_W];
    logic                      r_vld  [qob_pkg::QUO_W];

    for (genvar k = 0; k < qob_pkg::QUO_W; k++) begin : g_stage
        localparam int B = qob_pkg::QUO_W - 1 - k;
        logic [qob_pkg::REM_W-1:0] rem_in [qob_pkg::NUM_LANE];
        logic [qob_pkg::QUO_W-1:0] quo_in [qob_pkg::NUM_LANE];
        logic [qob_pkg::ROOT_W:0]  dvs_in;
        qob_pkg::t_div_side        side_in;
        logic                      vld_in;
        logic [qob_pkg::REM_W-1:0] dvs_sh;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < qob_pkg::NUM_LANE; l++) begin
                    rem_in[l] = i_dvd[l];
                    quo_in[l] = '0;
                end
            end
            assign dvs_in  = i_dvs;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < qob_pkg::NUM_LANE; l++) begin
                    rem_in[l] = r_rem[k-1][l];
                    quo_in[l] = r_quo[k-1][l];
                end
            end
            assign dvs_in  = r_dvs[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign dvs_sh = qob_pkg::REM_W'(dvs_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dvs[k]  <= dvs_in;
            r_side[k] <= side_in;
            for (int l = 0; l < qob_pkg::NUM_LANE; l++) begin
                if (rem_in[l] >= dvs_sh) begin
                    r_rem[k][l] <= rem_in[l] - dvs_sh;
                    r_quo[k][l] <= quo_in[l] | (qob_pkg::QUO_W'(1) << B);
                end else begin
                    r_rem[k][l] <= rem_in[l];
                    r_quo[k][l] <= quo_in[l];
                end
            end
        end
    end

    assign o_valid = r_vld[qob_pkg::QUO_W-1];
    assign o_side  = r_side[qob_pkg::QUO_W-1];
    always_comb begin
        for (int l = 0; l < qob_pkg::NUM_LANE; l++) begin
            o_quo[l] = r_quo[qob_pkg::QUO_W-1][l];
        end
    end

endmodule

@@ sv/quaternion_to_orientation_basis.sv @@
// Orientation basis from a quaternion: look, right and up axes, saturated to 16 bits.
// Depends on qob_pkg, qob_sqrt and qob_div.
//
// A request is taken at a rising edge with start high and busy low. Its fields are
// the quaternion parts i_quat_w .. i_quat_z, signed with 14 fraction bits.
// Nine vector components and the saturated flag come out together, shown for one
// cycle with o_strobe high; the receiver cannot hold them off.
//
// The block is a fixed pipeline: a new request may enter every cycle while busy is
// low, and results leave in request order, one per cycle. The depth is set by the
// square root of the norm square, one root bit per stage (32 stages), and the six
// divisions by the norm, one quotient bit per stage (18 stages); the remaining stages
// hold the input register, products, sums, divide setup, sign, cross product and output.
//
// Reset clears every valid bit, so no strobe follows a request that was still
// in flight. busy is high while reset is applied and until the first rising edge after
// reset is released, and low otherwise.
module quaternion_to_orientation_basis (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [qob_pkg::Q_W-1:0]  i_quat_w,
    input  logic signed [qob_pkg::Q_W-1:0]  i_quat_x,
    input  logic signed [qob_pkg::Q_W-1:0]  i_quat_y,
    input  logic signed [qob_pkg::Q_W-1:0]  i_quat_z,
    output logic                            o_strobe,
    output logic signed [qob_pkg::OUT_W-1:0] o_look_x,
    output logic signed [qob_pkg::OUT_W-1:0] o_look_y,
    output logic signed [qob_pkg::OUT_W-1:0] o_look_z,
    output logic signed [qob_pkg::OUT_W-1:0] o_right_x,
    output logic signed [qob_pkg::OUT_W-1:0] o_right_y,
    output logic signed [qob_pkg::OUT_W-1:0] o_right_z,
    output logic signed [qob_pkg::OUT_W-1:0] o_up_x,
    output logic signed [qob_pkg::OUT_W-1:0] o_up_y,
    output logic signed [qob_pkg::OUT_W-1:0] o_up_z,
    output logic                            o_saturated
);

    localparam int NL = qob_pkg::NUM_LANE;

    logic r_busy;
    logic accept;

    // Stage 0: input register.
    logic                           r_v0;
    logic signed [qob_pkg::Q_W-1:0] r_qw, r_qx, r_qy, r_qz;

    // Stage 1: products.
    logic                              r_v1;
    logic signed [qob_pkg::PROD_W-1:0] r_ww, r_xx, r_yy, r_zz;
    logic signed [qob_pkg::PROD_W-1:0] r_xz, r_wy, r_yz, r_wx, r_xy, r_wz;

    // Stage 2: norm square and numerators.
    logic                          r_v2;
    logic [qob_pkg::SUM_W-1:0]     r_sum;
    logic signed [qob_pkg::N_W-1:0] r_num [NL];
    logic signed [qob_pkg::N_W-1:0] n_num [NL];
    logic [qob_pkg::SUM_W-1:0]     n_sum;

    // Numerators and zero flag wait beside the root pipeline.
    logic signed [qob_pkg::N_W-1:0] r_nd [qob_pkg::ROOT_W][NL];
    logic                          r_zd [qob_pkg::ROOT_W];

    logic                       sq_valid;
    logic [qob_pkg::ROOT_W-1:0] sq_root;

    // Stage 3: divide setup.
    logic                      r_v3;
    logic [qob_pkg::REM_W-1:0] r_dvd [NL];
    logic [qob_pkg::ROOT_W:0]  r_dvs;
    qob_pkg::t_div_side        r_side3;

    logic                      dv_valid;
    logic [qob_pkg::QUO_W-1:0] dv_quo [NL];
    qob_pkg::t_div_side        dv_side;

    // Stage 4: signed look and right.
    logic                            r_v4;
    logic signed [qob_pkg::LR_W-1:0] r_lr4 [NL];
    logic signed [qob_pkg::LR_W-1:0] n_lr4 [NL];

    // Stage 5: cross products.
    logic                              r_v5;
    logic signed [qob_pkg::LR_W-1:0]   r_lr5 [NL];
    logic signed [qob_pkg::UP_P_W-1:0] r_pa [3];
    logic signed [qob_pkg::UP_P_W-1:0] r_pb [3];

    // Stage 6: output.
    logic                             r_v6;
    logic signed [qob_pkg::OUT_W-1:0] r_out [3 * 3];
    logic                             r_sat;
    logic signed [qob_pkg::OUT_W-1:0] n_out [3 * 3];
    logic                             n_sat;

    assign accept = start && !busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_v0   <= accept;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_v3   <= sq_valid;
            r_v4   <= dv_valid;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qw <= i_quat_w;
            r_qx <= i_quat_x;
            r_qy <= i_quat_y;
            r_qz <= i_quat_z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ww <= r_qw * r_qw;
        r_xx <= r_qx * r_qx;
        r_yy <= r_qy * r_qy;
        r_zz <= r_qz * r_qz;
        r_xz <= r_qx * r_qz;
        r_wy <= r_qw * r_qy;
        r_yz <= r_qy * r_qz;
        r_wx <= r_qw * r_qx;
        r_xy <= r_qx * r_qy;
        r_wz <= r_qw * r_qz;
    end

    // Look rotates (0,0,-1) and right rotates (1,0,0); the numerators below are the
    // vector part of q v conj(q) written out for those two axes.
    always_comb begin
        logic signed [qob_pkg::N_W-1:0] ww, xx, yy, zz, xz, wy, yz, wx, xy, wz;
        ww = qob_pkg::N_W'(r_ww);
        xx = qob_pkg::N_W'(r_xx);
        yy = qob_pkg::N_W'(r_yy);
        zz = qob_pkg::N_W'(r_zz);
        xz = qob_pkg::N_W'(r_xz);
        wy = qob_pkg::N_W'(r_wy);
        yz = qob_pkg::N_W'(r_yz);
        wx = qob_pkg::N_W'(r_wx);
        xy = qob_pkg::N_W'(r_xy);
        wz = qob_pkg::N_W'(r_wz);
        n_num[0] = -((xz + wy) <<< 1);
        n_num[1] = (wx - yz) <<< 1;
        n_num[2] = xx + yy - ww - zz;
        n_num[3] = ww + xx - yy - zz;
        n_num[4] = (xy + wz) <<< 1;
        n_num[5] = (xz - wy) <<< 1;
        n_sum = qob_pkg::SUM_W'($unsigned(r_ww)) + qob_pkg::SUM_W'($unsigned(r_xx))
              + qob_pkg::SUM_W'($unsigned(r_yy)) + qob_pkg::SUM_W'($unsigned(r_zz));
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        for (int l = 0; l < NL; l++) begin
            r_num[l] <= n_num[l];
        end
    end

    qob_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_rad   (qob_pkg::RAD_W'(r_sum) << (2 * qob_pkg::GUARD_BITS)),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_zd[0] <= (r_sum == '0);
        for (int l = 0; l < NL; l++) begin
            r_nd[0][l] <= r_num[l];
        end
        for (int s = 1; s < qob_pkg::ROOT_W; s++) begin
            r_zd[s] <= r_zd[s-1];
            for (int l = 0; l < NL; l++) begin
                r_nd[s][l] <= r_nd[s-1][l];
            end
        end
    end

    // Rounding half away from zero: divide (2|n| * 2^guard + m) by 2m.
    always_ff @(posedge i_clk) begin
        logic signed [qob_pkg::N_W-1:0] nv;
        logic [qob_pkg::N_W-1:0]        mag;
        r_dvs        <= {sq_root, 1'b0};
        r_side3.zero <= r_zd[qob_pkg::ROOT_W-1];
        for (int l = 0; l < NL; l++) begin
            nv  = r_nd[qob_pkg::ROOT_W-1][l];
            mag = nv[qob_pkg::N_W-1] ? $unsigned(-nv) : $unsigned(nv);
            r_side3.neg[l] <= nv[qob_pkg::N_W-1];
            r_dvd[l] <= (qob_pkg::REM_W'(mag) << (qob_pkg::GUARD_BITS + 1))
                      + qob_pkg::REM_W'(sq_root);
        end
    end

    qob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_dvd   (r_dvd),
        .i_dvs   (r_dvs),
        .i_side  (r_side3),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // A zero quaternion divides by zero; its quotients are replaced by zero here.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (dv_side.zero) begin
                n_lr4[l] = '0;
            end else if (dv_side.neg[l]) begin
                n_lr4[l] = -$signed(dv_quo[l]);
            end else begin
                n_lr4[l] = $signed(dv_quo[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_lr4[l] <= n_lr4[l];
            r_lr5[l] <= r_lr4[l];
        end
    end

    // up = right x look, from the unclipped values; lanes 0..2 look, 3..5 right.
    always_ff @(posedge i_clk) begin
        r_pa[0] <= r_lr4[4] * r_lr4[2];
        r_pb[0] <= r_lr4[5] * r_lr4[1];
        r_pa[1] <= r_lr4[5] * r_lr4[0];
        r_pb[1] <= r_lr4[3] * r_lr4[2];
        r_pa[2] <= r_lr4[3] * r_lr4[1];
        r_pb[2] <= r_lr4[4] * r_lr4[0];
    end

    always_comb begin
        logic signed [qob_pkg::UP_D_W-1:0] diff;
        logic [qob_pkg::UP_D_W-1:0]        mag;
        logic [qob_pkg::UP_D_W-1:0]        rq;
        logic signed [qob_pkg::UP_D_W-1:0] up;
        logic [qob_pkg::OUT_W:0]           s;
        n_sat = 1'b0;
        for (int l = 0; l < NL; l++) begin
            s = qob_pkg::sat_out(qob_pkg::UP_D_W'(r_lr5[l]));
            n_out[l] = $signed(s[qob_pkg::OUT_W-1:0]);
            n_sat = n_sat | s[qob_pkg::OUT_W];
        end
        for (int i = 0; i < 3; i++) begin
            diff = qob_pkg::UP_D_W'(r_pa[i]) - qob_pkg::UP_D_W'(r_pb[i]);
            mag  = diff[qob_pkg::UP_D_W-1] ? $unsigned(-diff) : $unsigned(diff);
            rq   = (mag + (qob_pkg::UP_D_W'(1) << (qob_pkg::FRACTION_BITS - 1)))
                   >> qob_pkg::FRACTION_BITS;
            up   = diff[qob_pkg::UP_D_W-1] ? -$signed(rq) : $signed(rq);
            s    = qob_pkg::sat_out(up);
            n_out[NL + i] = $signed(s[qob_pkg::OUT_W-1:0]);
            n_sat = n_sat | s[qob_pkg::OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        for (int i = 0; i < 3 * 3; i++) begin
            r_out[i] <= n_out[i];
        end
    end

    assign o_strobe    = r_v6;
    assign o_look_x    = r_out[0];
    assign o_look_y    = r_out[1];
    assign o_look_z    = r_out[2];
    assign o_right_x   = r_out[3];
    assign o_right_y   = r_out[4];
    assign o_right_z   = r_out[5];
    assign o_up_x      = r_out[6];
    assign o_up_y      = r_out[7];
    assign o_up_z      = r_out[8];
    assign o_saturated = r_sat;

endmodule

@@ sv/qob_checker.sv @@
// Port-level checks for the quaternion orientation basis block, bound to its top level.
// Depends on qob_pkg for the pipeline latency and output limits.
module qob_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic signed [qob_pkg::Q_W-1:0]   i_quat_w,
    input logic signed [qob_pkg::Q_W-1:0]   i_quat_x,
    input logic signed [qob_pkg::Q_W-1:0]   i_quat_y,
    input logic signed [qob_pkg::Q_W-1:0]   i_quat_z,
    input logic                             o_strobe,
    input logic signed [qob_pkg::OUT_W-1:0] o_look_x,
    input logic signed [qob_pkg::OUT_W-1:0] o_look_y,
    input logic signed [qob_pkg::OUT_W-1:0] o_look_z,
    input logic signed [qob_pkg::OUT_W-1:0] o_right_x,
    input logic signed [qob_pkg::OUT_W-1:0] o_right_y,
    input logic signed [qob_pkg::OUT_W-1:0] o_right_z,
    input logic signed [qob_pkg::OUT_W-1:0] o_up_x,
    input logic signed [qob_pkg::OUT_W-1:0] o_up_y,
    input logic signed [qob_pkg::OUT_W-1:0] o_up_z,
    input logic                             o_saturated
);

    logic zero_req;
    logic any_limit;

    assign zero_req = start && !busy && i_quat_w == '0 && i_quat_x == '0
                   && i_quat_y == '0 && i_quat_z == '0;

    function automatic logic at_limit(input logic signed [qob_pkg::OUT_W-1:0] v);
        return v == qob_pkg::OUT_MAX || v == qob_pkg::OUT_MIN;
    endfunction

    assign any_limit = at_limit(o_look_x) || at_limit(o_look_y) || at_limit(o_look_z)
                    || at_limit(o_right_x) || at_limit(o_right_y) || at_limit(o_right_z)
                    || at_limit(o_up_x) || at_limit(o_up_y) || at_limit(o_up_z);

    // Every result belongs to a request taken earlier, at the pipeline latency in qob_pkg.
    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, qob_pkg::LATENCY))
        else $error("result strobe without a matching request");

    // A zero quaternion yields zero vectors and no clipping.
    a_zero_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(zero_req, qob_pkg::LATENCY)) |->
        (o_look_x == '0 && o_look_y == '0 && o_look_z == '0 && o_right_x == '0
         && o_right_y == '0 && o_right_z == '0 && o_up_x == '0 && o_up_y == '0
         && o_up_z == '0 && !o_saturated))
        else $error("zero quaternion gave a nonzero result");

    // The clip flag is only set when some component sits at a range limit.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> any_limit)
        else $error("saturated flag set with no component at a limit");

    // Right after reset the block holds off requests with busy high.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

bind quaternion_to_orientation_basis qob_checker u_qob_checker (.*);
